@@ sv/ffca_pkg.sv @@
// Package for the first-fit contiguous allocator.
// Holds field widths, tag and opcode constants and the result struct.
// No dependencies.
package ffca_pkg;

    localparam int DEF_MEMORY_UNITS = 1024;

    localparam int OWNER_W = 8;
    localparam int SIZE_W  = 11;
    localparam int START_W = 10;

    localparam logic [OWNER_W-1:0] FREE_TAG = 8'hFF;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] start_unit;
    } t_result;

endpackage

@@ sv/ffca_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ffca_out_reg.sv @@
// Output holding register for allocator results, valid/ready toward the sink.
// Depends on ffca_pkg.
module ffca_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  ffca_pkg::t_result i_res,
    output logic             o_res_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_success,
    output logic [ffca_pkg::START_W-1:0] o_start_unit
);
    import ffca_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    n_valid;

    assign o_res_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_res_valid && o_res_ready) begin
            n_valid = 1'b1;
        end else if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid      = r_valid;
    assign o_success    = r_res.success;
    assign o_start_unit = r_res.start_unit;

endmodule

@@ sv/ffca_engine.sv @@
// Allocator sequencer: clear pass, release sweep, first-fit scan and run fill
// over the owner map RAM (registered read). Depends on ffca_pkg.
module ffca_engine #(
    parameter int MEMORY_UNITS = ffca_pkg::DEF_MEMORY_UNITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [ffca_pkg::OWNER_W-1:0]  i_owner_id,
    input  logic [ffca_pkg::SIZE_W-1:0]   i_request_size,
    output logic                          o_res_valid,
    output ffca_pkg::t_result             o_res,
    input  logic                          i_res_ready,
    output logic                          o_we,
    output logic [$clog2(MEMORY_UNITS)-1:0] o_waddr,
    output logic [ffca_pkg::OWNER_W-1:0]  o_wdata,
    output logic [$clog2(MEMORY_UNITS)-1:0] o_raddr,
    input  logic [ffca_pkg::OWNER_W-1:0]  i_rdata
);
    import ffca_pkg::*;

    localparam int AW = $clog2(MEMORY_UNITS);
    localparam int CW = $clog2(MEMORY_UNITS + 1);
    localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam logic [CW-1:0] CNT_END  = CW'(MEMORY_UNITS);
    localparam logic [CW-1:0] CNT_LAST = CW'(MEMORY_UNITS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_REL   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FILL  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_chk_addr, n_chk_addr;
    logic [OWNER_W-1:0]  r_owner, n_owner;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [CW-1:0]       r_run, n_run;
    logic [AW-1:0]       r_start, n_start;
    logic [AW-1:0]       r_fill_addr, n_fill_addr;
    logic [SIZE_W-1:0]   r_fill_left, n_fill_left;
    t_result             r_res, n_res;

    logic [CW-1:0]       run_inc;
    logic [AW-1:0]       run_start;
    logic [SW-1:0]       start_ext;
    logic                issuing;

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;
    assign o_raddr     = r_cnt[AW-1:0];
    assign issuing     = (r_cnt != CNT_END);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_chk_addr  = r_cnt[AW-1:0];
        n_owner     = r_owner;
        n_size      = r_size;
        n_run       = r_run;
        n_start     = r_start;
        n_fill_addr = r_fill_addr;
        n_fill_left = r_fill_left;
        n_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = r_cnt[AW-1:0];
        o_wdata     = FREE_TAG;
        run_inc     = r_run + CW'(1);
        run_start   = (r_run == '0) ? r_chk_addr : r_start;
        start_ext   = SW'(run_start);

        case (r_state)
            S_CLEAR: begin
                o_we  = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                n_run = '0;
                if (i_valid) begin
                    n_owner = i_owner_id;
                    n_size  = i_request_size;
                    n_res   = '0;
                    if (i_operation == OP_RELEASE) begin
                        n_res.success = 1'b1;
                        n_state       = S_REL;
                    end else if (i_request_size == '0 || i_owner_id == FREE_TAG) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_REL: begin
                // read entry u while entry u-1 is checked and freed if it matches the owner
                if (issuing) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend && i_rdata == r_owner) begin
                    o_we    = 1'b1;
                    o_waddr = r_chk_addr;
                end
                if (!issuing && !r_pend) begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    if (i_rdata == FREE_TAG) begin
                        n_run   = run_inc;
                        n_start = run_start;
                        if (SW'(run_inc) >= SW'(r_size)) begin
                            n_pend           = 1'b0;
                            n_fill_addr      = run_start;
                            n_fill_left      = r_size;
                            n_res.success    = 1'b1;
                            n_res.start_unit = start_ext[START_W-1:0];
                            n_state          = S_FILL;
                        end
                    end else begin
                        n_run = '0;
                    end
                end else if (!issuing) begin
                    n_state = S_RESP;
                end
            end
            S_FILL: begin
                o_we        = 1'b1;
                o_waddr     = r_fill_addr;
                o_wdata     = r_owner;
                n_fill_addr = r_fill_addr + AW'(1);
                n_fill_left = r_fill_left - SIZE_W'(1);
                if (r_fill_left == SIZE_W'(1)) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
        r_chk_addr  <= n_chk_addr;
        r_owner     <= n_owner;
        r_size      <= n_size;
        r_run       <= n_run;
        r_start     <= n_start;
        r_fill_addr <= n_fill_addr;
        r_fill_left <= n_fill_left;
        r_res       <= n_res;
    end

endmodule

@@ sv/first_fit_contiguous_allocator_top.sv @@
// First-fit contiguous allocator, top level.
// Request channel (i_valid/o_ready): i_operation allocates (0) a run of
//   i_request_size units for i_owner_id, or releases (1) all units of that owner.
// Result channel (o_valid/i_ready): o_success and o_start_unit, one per request.
// The owner map sits in one RAM of MEMORY_UNITS 8-bit tags, with a registered read.
// After reset a clearing pass writes the free tag to every entry, one per cycle,
//   with o_ready low.
// Release sweeps the whole map before its result is shown.
//   Allocate scans from unit 0 until the run is found, writes the run's units
//   one per cycle, then shows the result; a failed scan sweeps the whole map.
//   Zero size or free-tag owner answers without touching the map.
// One request is worked at a time, over the RAM's single read and write port.
// A result waits in an output register while i_ready is low; a finished request
//   holds in the engine until that register frees, and o_ready stays low.
// Depends on ffca_pkg, ffca_ram, ffca_engine, ffca_out_reg.
module first_fit_contiguous_allocator_top #(
    parameter int MEMORY_UNITS = ffca_pkg::DEF_MEMORY_UNITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [ffca_pkg::OWNER_W-1:0]  i_owner_id,
    input  logic [ffca_pkg::SIZE_W-1:0]   i_request_size,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_success,
    output logic [ffca_pkg::START_W-1:0]  o_start_unit
);
    import ffca_pkg::*;

    localparam int AW = $clog2(MEMORY_UNITS);

    logic               we;
    logic [AW-1:0]      waddr;
    logic [OWNER_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [OWNER_W-1:0] rdata;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    ffca_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (MEMORY_UNITS)
    ) u_owner_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ffca_engine #(
        .MEMORY_UNITS (MEMORY_UNITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_owner_id     (i_owner_id),
        .i_request_size (i_request_size),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_ready    (res_ready),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

    ffca_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_res_ready  (res_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_success    (o_success),
        .o_start_unit (o_start_unit)
    );

endmodule

@@ sim/testbench.sv @@
// Testbench for first_fit_contiguous_allocator_top: directed corner and hole requests, then random
// allocate/release traffic checked against an in-bench owner map with random idling.
// Depends on ffca_pkg and the allocator RTL.
`timescale 1ns / 100ps

module testbench;
    import ffca_pkg::*;

    localparam int          MEM_UNITS    = DEF_MEMORY_UNITS;
    localparam int unsigned CYCLE_LIMIT  = 8_000_000;
    localparam int          TAIL_CYCLES  = 2 * MEM_UNITS + 32;
    localparam int          RESULT_HOLD  = 5000;
    localparam int          OWNER_POOL   = 12;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic                  i_operation    = OP_ALLOC;
    logic [OWNER_W-1:0]    i_owner_id     = '0;
    logic [SIZE_W-1:0]     i_request_size = '0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic                  o_success;
    logic [START_W-1:0]    o_start_unit;

    // shadow owner map and the grants still owed by the block
    logic [OWNER_W-1:0]    unit_owner [MEM_UNITS];
    t_result               grant_queue [$];

    int unsigned           mismatch_count     = 0;
    int unsigned           cycle_count        = 0;
    int unsigned           result_hold_cycles = 0;
    bit                    idle_enable        = 1'b1;

    // owners used by well-formed traffic; together they toggle every owner bit
    logic [OWNER_W-1:0]    owner_pool [OWNER_POOL] = '{8'h00, 8'h01, 8'h02, 8'h7F, 8'h80, 8'hAA,
                                                       8'h55, 8'hC3, 8'hFE, 8'h3C, 8'h10, 8'hE7};

    first_fit_contiguous_allocator_top #(
        .MEMORY_UNITS(MEM_UNITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_owner_id     (i_owner_id),
        .i_request_size (i_request_size),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_success      (o_success),
        .o_start_unit   (o_start_unit)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : map_clear
        for (int u = 0; u < MEM_UNITS; u++)
            unit_owner[u] = FREE_TAG;
    end

    // Applies one request to the shadow map, returns the grant the block should give.
    function automatic t_result first_fit_grant(input logic op, input logic [OWNER_W-1:0] owner,
                                                input logic [SIZE_W-1:0] size);
        t_result grant;
        int      run_len;
        int      run_start;
        bit      found;
        grant     = '0;
        run_len   = 0;
        run_start = 0;
        found     = 1'b0;
        if (op == OP_RELEASE) begin
            grant.success = 1'b1;
            if (owner != FREE_TAG) begin
                for (int u = 0; u < MEM_UNITS; u++)
                    if (unit_owner[u] == owner)
                        unit_owner[u] = FREE_TAG;
            end
            return grant;
        end
        if (size == 0 || owner == FREE_TAG)
            return grant;
        for (int u = 0; u < MEM_UNITS && !found; u++) begin
            if (unit_owner[u] == FREE_TAG) begin
                if (run_len == 0)
                    run_start = u;
                run_len++;
                if (run_len >= size)
                    found = 1'b1;
            end else begin
                run_len = 0;
            end
        end
        if (found) begin
            for (int u = run_start; u < run_start + size; u++)
                unit_owner[u] = owner;
            grant.success    = 1'b1;
            grant.start_unit = run_start[START_W-1:0];
        end
        return grant;
    endfunction

    task automatic send_request(input logic op, input logic [OWNER_W-1:0] owner,
                                input logic [SIZE_W-1:0] size);
        int gap;
        gap = idle_enable ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_owner_id     <= owner;
        i_request_size <= size;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        grant_queue.push_back(first_fit_grant(op, owner, size));
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (grant_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly pool owners allocating and releasing; a tail of off-pool and malformed requests.
    task automatic random_request();
        int                 pick;
        logic               op;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size;
        pick  = $urandom_range(0, 99);
        op    = OP_ALLOC;
        owner = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
        size  = SIZE_W'($urandom_range(0, 2047));
        if (pick < 45) begin
            size = SIZE_W'($urandom_range(1, 24));
        end else if (pick < 60) begin
            size = SIZE_W'($urandom_range(25, 200));
        end else if (pick < 64) begin
            size = SIZE_W'($urandom_range(201, 1024));
        end else if (pick < 90) begin
            op = OP_RELEASE;
        end else if (pick < 95) begin
            owner = OWNER_W'($urandom_range(0, 255));
            size  = SIZE_W'($urandom_range(0, 63));
        end else begin
            op    = $urandom_range(0, 1) ? OP_RELEASE : OP_ALLOC;
            owner = OWNER_W'($urandom_range(0, 255));
        end
        send_request(op, owner, size);
    endtask

    task automatic flag_mismatch(input string what, input t_result want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected success=%0b start=%0d, got success=%0b start=%0d",
                     $time, what, want.success, want.start_unit, o_success, o_start_unit);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (grant_queue.size() == 0) begin
                want = '0;
                flag_mismatch("unexpected result", want);
            end else begin
                want = grant_queue.pop_front();
                if (o_success !== want.success || o_start_unit !== want.start_unit)
                    flag_mismatch("wrong result", want);
            end
        end
    end

    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (result_hold_cycles != 0) begin
                i_ready <= 1'b0;
                repeat (result_hold_cycles) @(posedge i_clk);
                result_hold_cycles = 0;
            end
            gap = idle_enable ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    task automatic test_corner_requests();
        idle_enable = 1'b1;
        send_request(OP_ALLOC,   8'h00, 11'd1);
        send_request(OP_ALLOC,   8'hFE, 11'd0);      // zero size
        send_request(OP_ALLOC,   FREE_TAG, 11'd5);   // free tag cannot own
        send_request(OP_RELEASE, FREE_TAG, 11'd2047);
        send_request(OP_ALLOC,   8'h01, 11'd1024);   // one unit short
        send_request(OP_ALLOC,   8'h01, 11'd1023);   // map now full
        send_request(OP_ALLOC,   8'h02, 11'd1);
        send_request(OP_RELEASE, 8'h00, 11'd0);
        send_request(OP_ALLOC,   8'h03, 11'd2);
        send_request(OP_ALLOC,   8'h03, 11'd1);
        send_request(OP_RELEASE, 8'h01, 11'd1024);
        send_request(OP_RELEASE, 8'h03, 11'd7);
        send_request(OP_ALLOC,   8'hFE, 11'd1024);   // whole map
        send_request(OP_RELEASE, 8'hFE, 11'd0);
        send_request(OP_ALLOC,   8'h80, 11'd2047);
        send_request(OP_ALLOC,   8'h80, 11'd1025);
        send_request(OP_RELEASE, 8'hC8, 11'd0);      // owner holds nothing
        wait_results_done();
    endtask

    // A freed hole too small for the next request must be skipped, then reused.
    task automatic test_first_fit_holes();
        send_request(OP_ALLOC,   8'h0A, 11'd100);
        send_request(OP_ALLOC,   8'h0B, 11'd50);
        send_request(OP_ALLOC,   8'h0C, 11'd30);
        send_request(OP_RELEASE, 8'h0B, 11'd0);
        send_request(OP_ALLOC,   8'h0D, 11'd60);
        send_request(OP_ALLOC,   8'h0E, 11'd50);
        send_request(OP_RELEASE, 8'h0A, 11'd0);
        wait_results_done();
    endtask

    task automatic test_random_mix(input int count, input bit with_idle);
        idle_enable = with_idle;
        repeat (count) random_request();
        wait_results_done();
    endtask

    // Receiver stalls long enough that the block backs up and drops o_ready.
    task automatic test_result_backpressure();
        idle_enable        = 1'b0;
        result_hold_cycles = RESULT_HOLD;
        repeat (8) random_request();
        wait_results_done();
    endtask

    task automatic test_pause_for_results();
        idle_enable = 1'b1;
        repeat (4) random_request();
        wait_results_done();
        repeat (4) random_request();
        wait_results_done();
    endtask

    initial begin : main_flow
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_requests();
        test_first_fit_holes();
        test_random_mix(200, 1'b1);
        test_result_backpressure();
        test_random_mix(150, 1'b0);
        test_pause_for_results();
        test_random_mix(190, 1'b1);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        mismatch_count += grant_queue.size();
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
sv/ffca_pkg.sv
sv/ffca_ram.sv
sv/ffca_out_reg.sv
sv/ffca_engine.sv
sv/first_fit_contiguous_allocator_top.sv
sim/testbench.sv
